@@ rtl/core/pid_controller_clamped_defines.svh @@
// ----------------------------------------------------------------------------
// pid_controller_clamped_defines
// assertion macros shared by the pid controller rtl
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define PIDC_ASSERT_HOLDS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition must hold in the cycle after the trigger
`define PIDC_ASSERT_NEXT(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/core/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// shared widths, register codes, payload types and arithmetic helpers
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = DATA_W + 2;
  localparam int STAGES    = 5;
  localparam int REG_IDX_W = 3;

  // near-zero band, round(0.01 * 2^FRAC_BITS)
  localparam int TOL_INT = ((1 << FRAC_BITS) + 50) / 100;

  typedef logic signed [DATA_W-1:0] pidc_q_t;
  typedef logic signed [PROD_W-1:0] pidc_prod_w_t;
  typedef logic signed [SUM_W-1:0]  pidc_sum_t;

  localparam pidc_q_t TOL_Q = DATA_W'(TOL_INT);
  localparam pidc_q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam pidc_q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_TARGET   = 3'd3,
    REG_OUT_LOW  = 3'd4,
    REG_OUT_HIGH = 3'd5
  } pidc_reg_t;

  typedef struct packed {
    pidc_q_t gain_p;
    pidc_q_t gain_i;
    pidc_q_t gain_d;
    pidc_q_t target;
    pidc_q_t out_low;
    pidc_q_t out_high;
  } pidc_cfg_t;

  typedef struct packed {
    pidc_q_t err;
    pidc_q_t dmeas;
  } pidc_diff_t;

  typedef struct packed {
    pidc_prod_w_t prod_p;
    pidc_prod_w_t prod_i;
    pidc_prod_w_t prod_d;
    logic         near;
  } pidc_prod_t;

  typedef struct packed {
    pidc_q_t p;
    pidc_q_t integ;
    pidc_q_t d;
  } pidc_terms_t;

  typedef struct packed {
    pidc_q_t value;
    logic    hit;
  } pidc_clamp_t;

  // a - b, saturated to the data range
  function automatic pidc_q_t sat_diff(input pidc_q_t a, input pidc_q_t b);
    logic signed [DATA_W:0] d;
    d = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    if (d[DATA_W] != d[DATA_W-1]) begin
      return d[DATA_W] ? Q_MIN : Q_MAX;
    end
    return d[DATA_W-1:0];
  endfunction

  // full-width signed product
  function automatic pidc_prod_w_t mul_full(input pidc_q_t a, input pidc_q_t b);
    pidc_prod_w_t ea;
    pidc_prod_w_t eb;
    ea = {{DATA_W{a[DATA_W-1]}}, a};
    eb = {{DATA_W{b[DATA_W-1]}}, b};
    return ea * eb;
  endfunction

  // drop fraction bits (floor) and saturate to the data range
  function automatic pidc_q_t scale_sat(input pidc_prod_w_t p);
    pidc_prod_w_t s;
    logic [PROD_W-DATA_W:0] top;
    s   = p >>> FRAC_BITS;
    top = s[PROD_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return s[DATA_W-1:0];
    end
    return s[PROD_W-1] ? Q_MIN : Q_MAX;
  endfunction

  function automatic pidc_sum_t ext_sum(input pidc_q_t q);
    return {{(SUM_W-DATA_W){q[DATA_W-1]}}, q};
  endfunction

  // upper limit tested first, then the lower one
  function automatic pidc_clamp_t clamp_q(input pidc_sum_t v, input pidc_q_t lo,
                                          input pidc_q_t hi);
    pidc_clamp_t res;
    pidc_sum_t   elo;
    pidc_sum_t   ehi;
    elo = ext_sum(lo);
    ehi = ext_sum(hi);
    if (v > ehi) begin
      res.value = hi;
      res.hit   = 1'b1;
    end else if (v < elo) begin
      res.value = lo;
      res.hit   = 1'b1;
    end else begin
      res.value = v[DATA_W-1:0];
      res.hit   = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pid_controller_clamped.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped
// clamped pid controller, derivative on measurement, signed q16.16
// ----------------------------------------------------------------------------
// One measurement per input transaction gives one drive value per output
// transaction. The block takes a transaction every cycle unless all stages are full
// and the output stalls, and delivers each result through a five-register pipeline:
// input register, error/step subtract, gain multipliers, scaling plus the
// integral update, and the output clamp register. The integral is a
// single-stage loop, so back-to-back measurements need no spacing. Backpressure
// on the output stalls the pipeline stage by stage; empty stages fill in the
// meantime. Gains, target and limits are written through the cfg_ port and
// must only change while no transaction is in flight. After reset the integral
// and previous measurement are zero and the limits span the full range; no
// clearing pass is needed.
`default_nettype none

`include "pid_controller_clamped_defines.svh"

module pid_controller_clamped (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [pidc_pkg::DATA_W-1:0]       in_tdata,   // [31:0] measurement
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [pidc_pkg::DATA_W-1:0]            out_tdata,  // [31:0] drive
  output logic [0:0]                             out_tuser,  // [0] saturated
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [pidc_pkg::REG_IDX_W-1:0]    cfg_addr,
  input  wire logic [pidc_pkg::DATA_W-1:0]       cfg_wdata
);
  import pidc_pkg::*;

  pidc_cfg_t   cfg_r;
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] rdy;
  logic [STAGES-1:0] load;

  pidc_diff_t  diff_b;
  pidc_prod_t  prod_c;
  pidc_terms_t terms_d;
  pidc_q_t     drive;
  logic        saturated;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p   <= '0;
      cfg_r.gain_i   <= '0;
      cfg_r.gain_d   <= '0;
      cfg_r.target   <= '0;
      cfg_r.out_low  <= Q_MIN;
      cfg_r.out_high <= Q_MAX;
    end else if (cfg_we) begin
      case (pidc_reg_t'(cfg_addr))
        REG_GAIN_P:   cfg_r.gain_p   <= cfg_wdata;
        REG_GAIN_I:   cfg_r.gain_i   <= cfg_wdata;
        REG_GAIN_D:   cfg_r.gain_d   <= cfg_wdata;
        REG_TARGET:   cfg_r.target   <= cfg_wdata;
        REG_OUT_LOW:  cfg_r.out_low  <= cfg_wdata;
        REG_OUT_HIGH: cfg_r.out_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-stage ready: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int k = STAGES-2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    load[0]    = rdy[0] && in_tvalid;
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < STAGES; k++) begin
      load[k]    = rdy[k] && vld_r[k-1];
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage a/b: capture measurement, error and step
  pidc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_a (load[0]),
    .load_b (load[1]),
    .meas   (in_tdata),
    .cfg    (cfg_r),
    .diff_b (diff_b)
  );

  // stage c: gain products
  pidc_mul u_mul (
    .clk    (clk),
    .load_c (load[2]),
    .diff_b (diff_b),
    .cfg    (cfg_r),
    .prod_c (prod_c)
  );

  // stage d: scaled terms and integral update
  pidc_integ u_integ (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_d  (load[3]),
    .prod_c  (prod_c),
    .cfg     (cfg_r),
    .terms_d (terms_d)
  );

  // stage e: sum, clamp, result register
  pidc_out u_out (
    .clk       (clk),
    .load_e    (load[4]),
    .terms_d   (terms_d),
    .cfg       (cfg_r),
    .drive     (drive),
    .saturated (saturated)
  );

  assign in_tready    = rdy[0];
  assign out_tvalid   = vld_r[STAGES-1];
  assign out_tdata    = drive;
  assign out_tuser[0] = saturated;

  // input only backs up when every stage holds a transaction and the sink stalls
  `PIDC_ASSERT_HOLDS(a_stall_only_when_full, in_tready || ((&vld_r) && !out_tready), "input stalled with room in pipeline")

  // an item inside the near-zero band leaves a cleared integral behind
  `PIDC_ASSERT_NEXT(a_near_clears_integral, load[3] && prod_c.near, terms_d.integ == '0, "integral not cleared in near-zero band")

endmodule

`default_nettype wire

@@ rtl/core/pidc_front.sv @@
// ----------------------------------------------------------------------------
// pidc_front
// input register, error and measurement step, previous measurement store
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load_a,
  input  wire logic                load_b,
  input  wire pidc_pkg::pidc_q_t   meas,
  input  wire pidc_pkg::pidc_cfg_t cfg,
  output pidc_pkg::pidc_diff_t     diff_b
);
  import pidc_pkg::*;

  pidc_q_t    meas_a_r;
  pidc_q_t    prev_r;
  pidc_diff_t diff_r;
  pidc_diff_t diff_nxt;

  always_comb begin
    diff_nxt.err   = sat_diff(cfg.target, meas_a_r);
    diff_nxt.dmeas = sat_diff(meas_a_r, prev_r);
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      meas_a_r <= meas;
    end
    if (load_b) begin
      diff_r <= diff_nxt;
    end
  end

  // previous measurement follows items as they leave the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (load_b) begin
      prev_r <= meas_a_r;
    end
  end

  assign diff_b = diff_r;

endmodule

`default_nettype wire

@@ rtl/core/pidc_mul.sv @@
// ----------------------------------------------------------------------------
// pidc_mul
// three gain multipliers with registered full-width products
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_mul (
  input  wire logic                 clk,
  input  wire logic                 load_c,
  input  wire pidc_pkg::pidc_diff_t diff_b,
  input  wire pidc_pkg::pidc_cfg_t  cfg,
  output pidc_pkg::pidc_prod_t      prod_c
);
  import pidc_pkg::*;

  pidc_prod_t prod_r;
  pidc_prod_t prod_nxt;

  always_comb begin
    prod_nxt.prod_p = mul_full(cfg.gain_p, diff_b.err);
    prod_nxt.prod_i = mul_full(cfg.gain_i, diff_b.err);
    prod_nxt.prod_d = mul_full(cfg.gain_d, diff_b.dmeas);
    // |err| strictly inside the tolerance band
    prod_nxt.near   = (diff_b.err < TOL_Q) && (diff_b.err > -TOL_Q);
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_c = prod_r;

endmodule

`default_nettype wire

@@ rtl/core/pidc_integ.sv @@
// ----------------------------------------------------------------------------
// pidc_integ
// product scaling and the clamped running integral
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_integ (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load_d,
  input  wire pidc_pkg::pidc_prod_t prod_c,
  input  wire pidc_pkg::pidc_cfg_t  cfg,
  output pidc_pkg::pidc_terms_t     terms_d
);
  import pidc_pkg::*;

  pidc_q_t     integ_r;
  pidc_q_t     integ_nxt;
  pidc_q_t     iterm;
  pidc_clamp_t iclamp;
  pidc_terms_t terms_r;
  pidc_terms_t terms_nxt;

  always_comb begin
    iterm  = scale_sat(prod_c.prod_i);
    iclamp = clamp_q(ext_sum(integ_r) + ext_sum(iterm), cfg.out_low, cfg.out_high);
    // integral drops to zero inside the near-zero band
    integ_nxt       = prod_c.near ? '0 : iclamp.value;
    terms_nxt.p     = scale_sat(prod_c.prod_p);
    terms_nxt.d     = scale_sat(prod_c.prod_d);
    terms_nxt.integ = integ_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (load_d) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms_d = terms_r;

endmodule

`default_nettype wire

@@ rtl/core/pidc_out.sv @@
// ----------------------------------------------------------------------------
// pidc_out
// term sum, output clamp and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_out (
  input  wire logic                  clk,
  input  wire logic                  load_e,
  input  wire pidc_pkg::pidc_terms_t terms_d,
  input  wire pidc_pkg::pidc_cfg_t   cfg,
  output pidc_pkg::pidc_q_t          drive,
  output logic                       saturated
);
  import pidc_pkg::*;

  pidc_sum_t   sum;
  pidc_clamp_t oclamp;
  pidc_q_t     drive_r;
  logic        sat_r;

  always_comb begin
    sum    = ext_sum(terms_d.p) + ext_sum(terms_d.integ) - ext_sum(terms_d.d);
    oclamp = clamp_q(sum, cfg.out_low, cfg.out_high);
  end

  always_ff @(posedge clk) begin
    if (load_e) begin
      drive_r <= oclamp.value;
      sat_r   <= oclamp.hit;
    end
  end

  assign drive     = drive_r;
  assign saturated = sat_r;

endmodule

`default_nettype wire

@@ bench/tb_pid_controller_clamped.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped
// self-checking bench for the clamped pid controller
// ----------------------------------------------------------------------------
// Measurements are streamed in from a queue by a clocked driver. A clocked
// monitor predicts drive and the saturated flag for each accepted measurement
// and checks every result transaction in order against that prediction.
// Gains, target and limits are rewritten between phases while the block is
// idle. The run covers reset defaults, directed corner cases and many random
// settings, with random idling on both sides, one long output stall and one
// input pause.
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped;
  import pidc_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 8;     // pipeline is five stages deep
  localparam int RAND_SEGS    = 20;
  localparam int SEG_ITEMS    = 76;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_SEG     = 3;
  localparam int PAUSE_SEG    = 10;
  localparam int TIMEOUT_NS   = 5_000_000;

  // indexes past the register list, the block must ignore them
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam pidc_q_t Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    pidc_q_t drive;
    logic    clipped;
  } drive_exp_t;

  // clock, reset and block ports
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata   = '0;   // [31:0] measurement
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;         // [31:0] drive
  logic [0:0]           out_tuser;         // [0] saturated
  logic                 cfg_we     = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr   = '0;
  logic [DATA_W-1:0]    cfg_wdata  = '0;

  // predictor copy of the registers and the controller state
  pidc_q_t kp_set, ki_set, kd_set, target_set, low_set, high_set;
  pidc_q_t integ_m, prev_meas_m;

  pidc_q_t    meas_pending_q[$];
  drive_exp_t drive_exp_q[$];
  drive_exp_t exp_r;

  // idling controls set by the stimulus process, hold count and input handshake flag
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  bit          rx_hold_req  = 1'b0;
  int          rx_hold_left = 0;
  bit          in_taken     = 1'b0;

  pidc_q_t walk_meas = '0;

  int fail_cnt    = 0;
  int meas_cnt    = 0;
  int drive_cnt   = 0;
  int clip_cnt    = 0;
  int clear_cnt   = 0;
  int setting_cnt = 0;

  pid_controller_clamped u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // saturate an exact value to the signed 32-bit range
  function automatic longint sat_q(input longint v);
    if (v > longint'(Q_MAX)) return longint'(Q_MAX);
    if (v < longint'(Q_MIN)) return longint'(Q_MIN);
    return v;
  endfunction

  // fixed-point product, floor on the dropped fraction, then saturated
  function automatic longint q_mul(input pidc_q_t a, input pidc_q_t b);
    return sat_q((longint'(a) * longint'(b)) >>> FRAC_BITS);
  endfunction

  // upper limit tested first, then the lower one
  function automatic longint clip_to(input longint v, input pidc_q_t lo, input pidc_q_t hi,
                                     output logic hit);
    hit = 1'b1;
    if (v > longint'(hi)) return longint'(hi);
    if (v < longint'(lo)) return longint'(lo);
    hit = 1'b0;
    return v;
  endfunction

  // one control tick: updates the integral and previous measurement
  function automatic drive_exp_t predict_drive(input pidc_q_t meas);
    drive_exp_t res;
    longint     err;
    longint     step;
    longint     p_term;
    longint     d_term;
    longint     sum;
    logic       integ_hit;
    logic       hit;
    err    = sat_q(longint'(target_set) - longint'(meas));
    p_term = q_mul(kp_set, pidc_q_t'(err));
    step   = sat_q(longint'(meas) - longint'(prev_meas_m));
    d_term = q_mul(kd_set, pidc_q_t'(step));
    integ_m = pidc_q_t'(clip_to(longint'(integ_m) + q_mul(ki_set, pidc_q_t'(err)),
                                low_set, high_set, integ_hit));
    // near-zero error band clears the integral before it feeds drive
    if ((err < 0 ? -err : err) < TOL_INT) begin
      integ_m = '0;
      clear_cnt++;
    end
    sum = clip_to(p_term + longint'(integ_m) - d_term, low_set, high_set, hit);
    res.drive   = pidc_q_t'(sum);
    res.clipped = hit;
    prev_meas_m = meas;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: holds a transaction until taken, otherwise idles at random
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (meas_pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= meas_pending_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output ready: random stalls plus one long hold counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each input transaction, checks each output one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken = rst_n && ((in_tvalid && in_tready) === 1'b1);
    if (in_taken) begin
      drive_exp_q.push_back(predict_drive(pidc_q_t'(in_tdata)));
      meas_cnt++;
    end
    if (rst_n && ((out_tvalid && out_tready) === 1'b1)) begin
      drive_cnt++;
      if (drive_exp_q.size() == 0) begin
        fail_cnt++;
        $error("drive transaction with no measurement behind it: %0d", $signed(out_tdata));
      end else begin
        exp_r = drive_exp_q.pop_front();
        if (exp_r.clipped) clip_cnt++;
        if (out_tdata !== exp_r.drive) begin
          fail_cnt++;
          $error("drive mismatch: expected %0d, actual %0d", exp_r.drive,
                 $signed(out_tdata));
        end
        if (out_tuser[0] !== exp_r.clipped) begin
          fail_cnt++;
          $error("saturated mismatch: expected %0b, actual %0b", exp_r.clipped,
                 out_tuser[0]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // register write, mirrored into the predictor since the block is idle
  task automatic write_reg(input logic [REG_IDX_W-1:0] addr, input pidc_q_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    case (addr)
      REG_GAIN_P:   kp_set     = val;
      REG_GAIN_I:   ki_set     = val;
      REG_GAIN_D:   kd_set     = val;
      REG_TARGET:   target_set = val;
      REG_OUT_LOW:  low_set    = val;
      REG_OUT_HIGH: high_set   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued measurement has its result, then let the pipe settle
  task automatic wait_drained();
    while (meas_pending_q.size() != 0 || in_tvalid || drive_exp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pidc_q_t rand_span(input int unsigned span);
    return pidc_q_t'(longint'($urandom_range(2 * span)) - longint'(span));
  endfunction

  function automatic pidc_q_t pick_edge();
    case ($urandom_range(5))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return Q_ONE;
      4:       return -Q_ONE;
      default: return -1;
    endcase
  endfunction

  // mix of near-target, full-range, extreme and slowly moving samples
  function automatic pidc_q_t pick_meas();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return pidc_q_t'(target_set + rand_span(1000));
    if (r < 55) return pidc_q_t'($urandom);
    if (r < 65) return pick_edge();
    walk_meas = walk_meas + rand_span(1 << 17);
    return walk_meas;
  endfunction

  // one full set of registers for a random phase
  task automatic load_setting(input int kind);
    pidc_q_t gp, gi, gd, tg, lo, hi, tmp;
    gp = rand_span(1 << 18);
    gi = rand_span(1 << 14);
    gd = rand_span(1 << 18);
    tg = rand_span(1 << 22);
    lo = Q_MIN;
    hi = Q_MAX;
    case (kind)
      1: begin
        // raw 32-bit values, products saturate often
        gp = pidc_q_t'($urandom);
        gi = pidc_q_t'($urandom);
        gd = pidc_q_t'($urandom);
        tg = pidc_q_t'($urandom);
        lo = pidc_q_t'($urandom);
        hi = pidc_q_t'($urandom);
        if (lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end
      2: begin
        gp = pick_edge();
        gi = pick_edge();
        gd = pick_edge();
        tg = pick_edge();
      end
      3: begin
        // crossed limits, upper limit tested first
        lo = $urandom_range(1) ? Q_MAX : pidc_q_t'($urandom_range(1 << 20));
        hi = $urandom_range(1) ? Q_MIN : -pidc_q_t'($urandom_range(1 << 20));
      end
      4: begin
        lo = pidc_q_t'(tg - pidc_q_t'($urandom_range(1 << 20)));
        hi = pidc_q_t'(tg + pidc_q_t'($urandom_range(1 << 20)));
      end
      default: ;
    endcase
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, pidc_q_t'($urandom));
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_TARGET, tg);
    write_reg(REG_OUT_LOW, lo);
    write_reg(REG_OUT_HIGH, hi);
    setting_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    // reset values of the registers and state
    kp_set      = '0;
    ki_set      = '0;
    kd_set      = '0;
    target_set  = '0;
    low_set     = Q_MIN;
    high_set    = Q_MAX;
    integ_m     = '0;
    prev_meas_m = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero gains give zero drive whatever comes in
    meas_pending_q.push_back(32'sh1234_5678);
    meas_pending_q.push_back(Q_MIN);
    meas_pending_q.push_back(Q_MAX);
    wait_drained();

    // directed: moderate gains, tight limits, probe the near-zero band edges
    write_reg(REG_GAIN_P, 32'sh0002_0000);
    write_reg(REG_GAIN_I, 32'sh0000_8000);
    write_reg(REG_GAIN_D, Q_ONE);
    write_reg(REG_TARGET, Q_ONE);
    write_reg(REG_OUT_LOW, -32'sh0064_0000);
    write_reg(REG_OUT_HIGH, 32'sh0064_0000);
    setting_cnt++;
    meas_pending_q.push_back(Q_ONE);
    meas_pending_q.push_back(Q_ONE + 654);
    meas_pending_q.push_back(Q_ONE - 654);
    meas_pending_q.push_back(Q_ONE + 655);
    meas_pending_q.push_back(Q_ONE - 655);
    meas_pending_q.push_back(Q_ONE + 656);
    meas_pending_q.push_back(Q_MAX);
    // measurement step overflow in both directions
    meas_pending_q.push_back(Q_MIN);
    meas_pending_q.push_back(Q_MAX);
    meas_pending_q.push_back('0);
    meas_pending_q.push_back(-1);
    meas_pending_q.push_back(1);
    wait_drained();

    // directed: error overflow with extreme gains and full-range limits
    write_reg(REG_GAIN_P, Q_MAX);
    write_reg(REG_GAIN_I, Q_MIN);
    write_reg(REG_GAIN_D, Q_MAX);
    write_reg(REG_TARGET, Q_MAX);
    write_reg(REG_OUT_LOW, Q_MIN);
    write_reg(REG_OUT_HIGH, Q_MAX);
    setting_cnt++;
    meas_pending_q.push_back(Q_MIN);
    meas_pending_q.push_back(Q_MAX);
    meas_pending_q.push_back('0);
    meas_pending_q.push_back(Q_MIN);
    wait_drained();

    // random phases: sender-light/receiver-heavy idling, then the reverse, then none
    for (int seg = 0; seg < RAND_SEGS; seg++) begin
      load_setting(seg % 5);
      walk_meas = target_set;
      if (seg < RAND_SEGS / 3) begin
        tx_idle_pct = 14;
        rx_idle_pct = 77;
      end else if (seg < 2 * RAND_SEGS / 3) begin
        tx_idle_pct = 77;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (seg == HOLD_SEG) begin
        // long output hold while measurements keep coming, fills the pipe
        tx_idle_pct = 0;
        rx_hold_req = 1'b1;
      end
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // sender pause mid-phase until every pending drive has come out
        if (seg == PAUSE_SEG && n == SEG_ITEMS / 2) wait_drained();
        meas_pending_q.push_back(pick_meas());
      end
      wait_drained();
    end

    $display("covered %0d measurements over %0d register settings, %0d drive results checked",
             meas_cnt, setting_cnt, drive_cnt);
    $display("%0d drives clipped, %0d integral clears, one long output hold, one input pause",
             clip_cnt, clear_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d measurements pending", meas_pending_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pidc_pkg.sv
rtl/core/pidc_front.sv
rtl/core/pidc_mul.sv
rtl/core/pidc_integ.sv
rtl/core/pidc_out.sv
rtl/core/pid_controller_clamped.sv
bench/tb_pid_controller_clamped.sv
